@@ hw/rtl/blt_pkg.sv @@
`default_nettype none

package blt_pkg;

    localparam int COORD_W       = 6;
    localparam int DELTA2_W      = COORD_W + 1;
    localparam int ERR_W         = COORD_W + 3;
    localparam int GRID_SIZE_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    typedef logic [COORD_W-1:0]       coord_t;
    typedef logic [DELTA2_W-1:0]      delta2_t;
    typedef logic signed [ERR_W-1:0]  err_t;

    // One classified line request, expressed along its major and minor axes.
    typedef struct packed {
        logic    x_major;
        coord_t  maj;
        coord_t  min;
        coord_t  maj_end;
        logic    maj_neg;
        logic    min_neg;
        delta2_t dmaj2;
        delta2_t dmin2;
        err_t    err0;
    } line_rec_t;

endpackage

`default_nettype wire

@@ hw/rtl/blt_front.sv @@
`default_nettype none

module blt_front
    import blt_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
)(
    input  wire logic      push,
    input  wire logic      full,
    input  wire coord_t    start_x,
    input  wire coord_t    start_y,
    input  wire coord_t    end_x,
    input  wire coord_t    end_y,
    output logic           wr_en,
    output line_rec_t      rec
);

    localparam logic [COORD_W:0] GRID_LIM = (COORD_W+1)'(GRID_SIZE);
    localparam coord_t           COORD_MAX = COORD_W'(GRID_SIZE - 1);

    function automatic coord_t clamp(input coord_t v);
        coord_t r;
        r = ({1'b0, v} >= GRID_LIM) ? COORD_MAX : v;
        return r;
    endfunction

    coord_t               x0, y0, x1, y1;
    logic signed [COORD_W:0] dx, dy;
    coord_t               adx, ady;
    logic                 x_major;
    coord_t               dmaj_abs, dmin_abs;

    assign wr_en = push && !full;

    always_comb
    begin
        x0 = clamp(start_x);
        y0 = clamp(start_y);
        x1 = clamp(end_x);
        y1 = clamp(end_y);
        dx = signed'({1'b0, x1}) - signed'({1'b0, x0});
        dy = signed'({1'b0, y1}) - signed'({1'b0, y0});
        adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        // tie on the doubled deltas goes to x
        x_major  = (adx >= ady);
        dmaj_abs = x_major ? adx : ady;
        dmin_abs = x_major ? ady : adx;

        rec.x_major = x_major;
        rec.maj     = x_major ? x0 : y0;
        rec.min     = x_major ? y0 : x0;
        rec.maj_end = x_major ? x1 : y1;
        rec.maj_neg = x_major ? dx[COORD_W] : dy[COORD_W];
        rec.min_neg = x_major ? dy[COORD_W] : dx[COORD_W];
        rec.dmaj2   = {dmaj_abs, 1'b0};
        rec.dmin2   = {dmin_abs, 1'b0};
        rec.err0    = err_t'({2'b00, dmin_abs, 1'b0}) - err_t'({3'b000, dmaj_abs});
    end

endmodule

`default_nettype wire

@@ hw/rtl/blt_queue.sv @@
`default_nettype none

module blt_queue
    import blt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire line_rec_t wr_rec,
    output logic           full,
    input  wire logic      rd_en,
    output line_rec_t      rd_rec,
    output logic           q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    line_rec_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign q_empty = (count_reg == '0);
    assign rd_rec  = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/blt_back.sv @@
`default_nettype none

module blt_back
    import blt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_empty,
    input  wire line_rec_t q_rec,
    output logic           q_pop,
    input  wire logic      pop,
    output logic           empty,
    output coord_t         point_x,
    output coord_t         point_y,
    output logic           last_point
);

    logic      busy_reg, busy_next;
    logic      out_valid_reg, out_valid_next;
    line_rec_t cur_reg;
    coord_t    maj_reg, min_reg;
    err_t      err_reg;
    coord_t    out_x_reg, out_y_reg;
    logic      out_last_reg;

    logic      cur_last;
    logic      emit;
    logic      done;
    logic      load;
    logic      take;
    err_t      err_sub;
    err_t      err_next;
    coord_t    maj_next;
    coord_t    min_next;

    assign empty      = !out_valid_reg;
    assign point_x    = out_x_reg;
    assign point_y    = out_y_reg;
    assign last_point = out_last_reg;

    // major coordinate at its end means the whole line is done
    assign cur_last = (maj_reg == cur_reg.maj_end);
    assign emit     = busy_reg && (!out_valid_reg || pop);
    assign done     = emit && cur_last;
    assign load     = (!busy_reg || done) && !q_empty;
    assign q_pop    = load;

    always_comb
    begin
        // step the minor axis on a positive term, or a zero term going up
        take     = (!err_reg[ERR_W-1] && (err_reg != '0))
                || ((err_reg == '0) && !cur_reg.maj_neg);
        err_sub  = take ? err_t'({2'b00, cur_reg.dmaj2}) : '0;
        err_next = err_reg - err_sub + err_t'({2'b00, cur_reg.dmin2});
        maj_next = cur_reg.maj_neg ? maj_reg - 1'b1 : maj_reg + 1'b1;
        min_next = min_reg;
        if (take)
        begin
            min_next = cur_reg.min_neg ? min_reg - 1'b1 : min_reg + 1'b1;
        end

        busy_next = busy_reg;
        if (load)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_rec;
            maj_reg <= q_rec.maj;
            min_reg <= q_rec.min;
            err_reg <= q_rec.err0;
        end
        else if (emit)
        begin
            maj_reg <= maj_next;
            min_reg <= min_next;
            err_reg <= err_next;
        end

        if (emit)
        begin
            out_x_reg    <= cur_reg.x_major ? maj_reg : min_reg;
            out_y_reg    <= cur_reg.x_major ? min_reg : maj_reg;
            out_last_reg <= cur_last;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bresenham_line_tracer_top.sv @@
// Path: requests pass the queue and stepper; points leave from the result register.
// Throughput: the stepper emits one point per cycle while results are popped or the result
// register is free; a line has N points, N being at most GRID_SIZE (64 by default). A two-entry
// request queue and the result register let requests and result pops stall independently.
// Reset: rst_n (async, active low) empties the queue, idles the stepper and raises empty.
`default_nettype none

module bresenham_line_tracer_top
    import blt_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    output logic        full,
    input  wire coord_t start_x,
    input  wire coord_t start_y,
    input  wire coord_t end_x,
    input  wire coord_t end_y,
    output logic        empty,
    input  wire logic   pop,
    output coord_t      point_x,
    output coord_t      point_y,
    output logic        last_point
);

    logic      wr_en;
    line_rec_t wr_rec;
    line_rec_t rd_rec;
    logic      q_empty;
    logic      q_pop;

    blt_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .push    (push),
        .full    (full),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .wr_en   (wr_en),
        .rec     (wr_rec)
    );

    blt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_rec  (wr_rec),
        .full    (full),
        .rd_en   (q_pop),
        .rd_rec  (rd_rec),
        .q_empty (q_empty)
    );

    blt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_rec      (rd_rec),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point)
    );

endmodule

`default_nettype wire

@@ hw/rtl/blt_checker.sv @@
`default_nettype none

module blt_checker
    import blt_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   empty,
    input wire logic   pop,
    input wire coord_t point_x,
    input wire coord_t point_y,
    input wire logic   last_point
);

    logic               prev_valid_reg;
    coord_t             prev_x_reg, prev_y_reg;
    logic [COORD_W:0]   ddx, ddy;
    logic               near_x, near_y, moved;
    logic               beat;

    assign beat   = pop && !empty;
    assign ddx    = {1'b0, point_x} - {1'b0, prev_x_reg};
    assign ddy    = {1'b0, point_y} - {1'b0, prev_y_reg};
    assign near_x = (ddx == '0) || (ddx == (COORD_W+1)'(1)) || (ddx == '1);
    assign near_y = (ddy == '0) || (ddy == (COORD_W+1)'(1)) || (ddy == '1);
    assign moved  = (ddx != '0) || (ddy != '0);

    // track the previous popped point of a line still in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
        end
        else if (beat)
        begin
            prev_valid_reg <= !last_point;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat)
        begin
            prev_x_reg <= point_x;
            prev_y_reg <= point_y;
        end
    end

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result side not empty during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(point_x) && $stable(point_y)
                              && $stable(last_point)))
        else $error("waiting result changed while stalled");

    a_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && prev_valid_reg) |-> (near_x && near_y && moved))
        else $error("consecutive points of a line are not neighboring cells");

    a_no_pop_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result present right after reset");

endmodule

bind bresenham_line_tracer_top blt_checker u_blt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
);

`default_nettype wire

@@ tb/bresenham_line_tracer_checker.sv @@
module bresenham_line_tracer_checker
    import blt_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire logic   full,
    input  wire coord_t start_x,
    input  wire coord_t start_y,
    input  wire coord_t end_x,
    input  wire coord_t end_y,
    input  wire logic   empty,
    input  wire logic   pop,
    input  wire coord_t point_x,
    input  wire coord_t point_y,
    input  wire logic   last_point,
    output int          fail_count,
    output int          points_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } grid_point_t;

    grid_point_t pending_points[$];
    int          mismatches = 0;

    function automatic int on_grid(coord_t c);
        return (int'(c) >= GRID_SIZE) ? GRID_SIZE - 1 : int'(c);
    endfunction

    // Append every cell of the line from (x0,y0) to (x1,y1), start first.
    function automatic void trace_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
        int x, y, xe, ye;
        int step_x, step_y, ax2, ay2, err, n;
        x      = on_grid(x0);
        y      = on_grid(y0);
        xe     = on_grid(x1);
        ye     = on_grid(y1);
        step_x = (xe > x) ? 1 : ((xe < x) ? -1 : 0);
        step_y = (ye > y) ? 1 : ((ye < y) ? -1 : 0);
        ax2    = 2 * ((xe > x) ? xe - x : x - xe);
        ay2    = 2 * ((ye > y) ? ye - y : y - ye);
        pending_points.push_back('{x: coord_t'(x), y: coord_t'(y),
                                   last: (x == xe) && (y == ye)});
        n = 1;
        if (ax2 >= ay2) begin
            err = ay2 - ax2 / 2;
            while (x != xe && n < GRID_SIZE) begin
                // a zero error term steps the minor axis only when moving up
                if (err > 0 || (err == 0 && step_x > 0)) begin
                    err -= ax2;
                    y += step_y;
                end
                err += ay2;
                x += step_x;
                pending_points.push_back('{x: coord_t'(x), y: coord_t'(y), last: x == xe});
                n++;
            end
        end else begin
            err = ax2 - ay2 / 2;
            while (y != ye && n < GRID_SIZE) begin
                if (err > 0 || (err == 0 && step_y > 0)) begin
                    err -= ay2;
                    x += step_x;
                end
                err += ax2;
                y += step_y;
                pending_points.push_back('{x: coord_t'(x), y: coord_t'(y), last: y == ye});
                n++;
            end
        end
    endfunction

    always @(posedge clk) begin
        grid_point_t want;
        if (rst_n) begin
            // check the result beat before queueing the request of the same edge
            if (pop && !empty) begin
                if (pending_points.size() == 0) begin
                    mismatches++;
                    $display("%0t: point (%0d,%0d) last=%0b arrived with no line pending",
                             $time, point_x, point_y, last_point);
                end else begin
                    want = pending_points.pop_front();
                    if (point_x !== want.x) begin
                        mismatches++;
                        $display("%0t: point_x expected %0d actual %0d",
                                 $time, want.x, point_x);
                    end
                    if (point_y !== want.y) begin
                        mismatches++;
                        $display("%0t: point_y expected %0d actual %0d",
                                 $time, want.y, point_y);
                    end
                    if (last_point !== want.last) begin
                        mismatches++;
                        $display("%0t: last_point expected %0b actual %0b",
                                 $time, want.last, last_point);
                    end
                end
            end
            if (push && !full)
                trace_line(start_x, start_y, end_x, end_y);
        end
        fail_count <= mismatches;
        points_due <= pending_points.size();
    end

endmodule

@@ tb/bresenham_line_tracer_top_tb.sv @@
module bresenham_line_tracer_top_tb
    import blt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_LINES = 460;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 10;

    logic   clk     = 1'b0;
    logic   rst_n   = 1'b0;
    logic   push    = 1'b0;
    logic   pop     = 1'b0;
    coord_t start_x = '0;
    coord_t start_y = '0;
    coord_t end_x   = '0;
    coord_t end_y   = '0;
    logic   full;
    logic   empty;
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
    int     fail_count;
    int     points_due;

    int     lines_sent = 0;
    bit     calm       = 1'b0;

    always #5ns clk = ~clk;

    bresenham_line_tracer_top #(.GRID_SIZE(GRID_SIZE_DEF)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .empty      (empty),
        .pop        (pop),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point)
    );

    bresenham_line_tracer_checker #(.GRID_SIZE(GRID_SIZE_DEF)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .empty      (empty),
        .pop        (pop),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point),
        .fail_count (fail_count),
        .points_due (points_due)
    );

    // Offer one request and hold it until the beat, then maybe leave a gap.
    task automatic send_line(input coord_t sx, input coord_t sy,
                             input coord_t ex, input coord_t ey);
        push    <= 1'b1;
        start_x <= sx;
        start_y <= sy;
        end_x   <= ex;
        end_y   <= ey;
        do @(posedge clk); while (full);
        lines_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    function automatic coord_t nudge(coord_t c);
        int t;
        t = int'(c) + int'($urandom_range(0, 16)) - 8;
        return (t < 0) ? coord_t'(0) : ((t > 63) ? coord_t'(63) : coord_t'(t));
    endfunction

    initial begin : stimulus
        int     kind;
        coord_t sx, sy, ex, ey;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // zero-length lines at both corners
        send_line(6'd0, 6'd0, 6'd0, 6'd0);
        send_line(6'd63, 6'd63, 6'd63, 6'd63);
        // full-length axis lines both ways
        send_line(6'd0, 6'd21, 6'd63, 6'd21);
        send_line(6'd63, 6'd42, 6'd0, 6'd42);
        send_line(6'd42, 6'd0, 6'd42, 6'd63);
        send_line(6'd21, 6'd63, 6'd21, 6'd0);
        // pure diagonals with equal doubled deltas
        send_line(6'd0, 6'd0, 6'd63, 6'd63);
        send_line(6'd63, 6'd63, 6'd0, 6'd0);
        send_line(6'd63, 6'd0, 6'd0, 6'd63);
        send_line(6'd0, 6'd63, 6'd63, 6'd0);
        // zero error term, positive and negative major direction
        send_line(6'd0, 6'd0, 6'd2, 6'd1);
        send_line(6'd2, 6'd1, 6'd0, 6'd0);
        send_line(6'd0, 6'd0, 6'd1, 6'd2);
        send_line(6'd1, 6'd2, 6'd0, 6'd0);
        send_line(6'd30, 6'd30, 6'd34, 6'd28);
        // single steps
        send_line(6'd0, 6'd0, 6'd1, 6'd0);
        send_line(6'd63, 6'd63, 6'd63, 6'd62);
        // mixed octants
        send_line(6'd10, 6'd40, 6'd50, 6'd5);
        send_line(6'd50, 6'd5, 6'd10, 6'd40);
        send_line(6'd5, 6'd10, 6'd20, 6'd60);
        send_line(6'd20, 6'd60, 6'd5, 6'd10);
        send_line(6'd0, 6'd63, 6'd62, 6'd1);

        for (int i = 0; i < RANDOM_LINES; i++) begin
            calm = (i >= 200 && i < 240) || (i >= RANDOM_LINES - 60);
            kind = $urandom_range(0, 9);
            sx   = coord_t'($urandom_range(0, 63));
            sy   = coord_t'($urandom_range(0, 63));
            ex   = coord_t'($urandom_range(0, 63));
            ey   = coord_t'($urandom_range(0, 63));
            if (kind < 6) begin
                // mostly short lines to keep the run brief
                ex = nudge(sx);
                ey = nudge(sy);
            end else if (kind == 8) begin
                ex = sx;
                ey = sy;
            end else if (kind == 9) begin
                if ($urandom_range(0, 1) == 0)
                    ey = sy;
                else
                    ex = sx;
            end
            send_line(sx, sy, ex, ey);
        end
        push <= 1'b0;

        do @(posedge clk); while (points_due != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : drain
        int hold;
        bit long_done;
        hold      = 0;
        long_done = 1'b0;
        forever begin
            @(posedge clk);
            if (!long_done && lines_sent >= 30) begin
                // stall results long enough for the request side to back up
                long_done = 1'b1;
                pop <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end else if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 14) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
